/* rtl/core/lrs_pkg.sv */
package lrs_pkg;

   localparam int TIME_WIDTH_DEF  = 32;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int TIME_IN_WIDTH   = 32;
   localparam int DIV_WIDTH       = 32;
   localparam int RATE_WIDTH      = 17;
   localparam int DECAY_WIDTH     = 14;
   localparam int MODE_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [RATE_WIDTH-1:0] RATE_ONE = 17'd65536;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INIT_RATE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EPOCH     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DECAY     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TCONST    = 3'd4;

   // schedule modes; the spare code runs as a fixed rate
   localparam logic [MODE_WIDTH-1:0] MODE_FIXED = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_STEP  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_EXP   = 2'd2;

   localparam logic [MODE_WIDTH-1:0]     RST_MODE      = MODE_FIXED;
   localparam logic [RATE_WIDTH-1:0]     RST_INIT_RATE = 17'd6554;
   localparam logic [DIV_WIDTH-1:0]      RST_EPOCH     = 32'd1000;
   localparam logic [DECAY_WIDTH-1:0]    RST_DECAY     = 14'd9000;
   localparam logic [DIV_WIDTH-1:0]      RST_TCONST    = 32'd1000;

   localparam logic [DECAY_WIDTH-1:0] DECAY_FULL  = 14'd10000;
   localparam logic [DECAY_WIDTH-1:0] DECAY_ROUND = 14'd5000;
   localparam int RETAIN_STEPS_PER_CYCLE = 8;

   localparam int EXP_CUTOFF = 20;
   localparam logic [63:0] LOG2E_Q60 = 64'h1715_4765_2B82_FE17;

   // log2(e) rounded to fb fraction bits
   function automatic logic [63:0] log2e_fix(input int fb);
      return (LOG2E_Q60 + (64'd1 << (59 - fb))) >> (60 - fb);
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = value;
      r = '0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^-(2^-k) in fb fraction bits, built by repeated floor square roots
   function automatic logic [63:0] exp_root(input int k, input int fb);
      logic [63:0] root;
      root = isqrt64(64'd1 << (2 * fb - 1));
      for (int j = 1; j < k; j++) begin
         root = isqrt64(root << fb);
      end
      return root;
   endfunction

endpackage

/* rtl/core/learning_rate_schedule.sv */
// Channel   Direction  Handshake          Word
// req_      in         req_valid/stall    time_step, 32 bits, time in ticks
// rsp_      out        rsp_valid/stall    rate, 17 bits, unsigned Q1.16
// csr_      in         csr_valid/ready    csr_index 3 bits, csr_data 32 bits
//
// Takes one word per cycle while req_stall is low. Each time step passes in order
// through the long divider, the exp unit, the power unit and the output register.
// Reset clears the valid bits and loads the register defaults; csr_ready stays high.
// A stalled full output register freezes the datapath and sets req_stall in the same cycle.
module learning_rate_schedule
   import lrs_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [TIME_IN_WIDTH-1:0]    req_time_step,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [RATE_WIDTH-1:0]       rsp_rate,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_data
);

   localparam int QW = FRAC_BITS + 1;
   localparam int PW = RATE_WIDTH + QW;
   localparam logic [PW:0] R_HALF = (PW+1)'(1) << (FRAC_BITS - 1);

   // ---- configuration ----
   logic [MODE_WIDTH-1:0]  mode_ff;
   logic [RATE_WIDTH-1:0]  init_rate_ff;
   logic [DIV_WIDTH-1:0]   epoch_ff;
   logic [DECAY_WIDTH-1:0] decay_ff;
   logic [DIV_WIDTH-1:0]   tconst_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= RST_MODE;
         init_rate_ff <= RST_INIT_RATE;
         epoch_ff     <= RST_EPOCH;
         decay_ff     <= RST_DECAY;
         tconst_ff    <= RST_TCONST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODE:      mode_ff      <= csr_data[MODE_WIDTH-1:0];
            CSR_INIT_RATE: init_rate_ff <= csr_data[RATE_WIDTH-1:0];
            CSR_EPOCH:     epoch_ff     <= csr_data[DIV_WIDTH-1:0];
            CSR_DECAY:     decay_ff     <= csr_data[DECAY_WIDTH-1:0];
            CSR_TCONST:    tconst_ff    <= csr_data[DIV_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // ---- flow control ----
   logic rsp_valid_ff;
   logic advance;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // ---- divisor: zero length counts as one ----
   logic [DIV_WIDTH-1:0] div_raw;
   logic [DIV_WIDTH-1:0] divisor;

   assign div_raw = (mode_ff == MODE_STEP) ? epoch_ff : tconst_ff;
   assign divisor = (div_raw == '0) ? DIV_WIDTH'(1) : div_raw;

   logic                            div_valid;
   logic [TIME_WIDTH+FRAC_BITS-1:0] div_quot;

   lrs_div #(
      .TIME_WIDTH (TIME_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_time   (TIME_WIDTH'(req_time_step)),
      .divisor   (divisor),
      .out_valid (div_valid),
      .out_quot  (div_quot)
   );

   logic                  exp_valid;
   logic [TIME_WIDTH-1:0] exp_count;
   logic [QW-1:0]         exp_factor;

   lrs_exp #(
      .TIME_WIDTH (TIME_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_exp (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (div_valid),
      .in_quot    (div_quot),
      .out_valid  (exp_valid),
      .out_count  (exp_count),
      .out_factor (exp_factor)
   );

   logic [QW-1:0] retain;

   lrs_retain #(
      .FRAC_BITS (FRAC_BITS)
   ) u_retain (
      .clock  (clock),
      .decay  (decay_ff),
      .retain (retain)
   );

   logic          pow_valid;
   logic [QW-1:0] pow_step;
   logic [QW-1:0] pow_exp;

   lrs_pow #(
      .TIME_WIDTH (TIME_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_pow (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (exp_valid),
      .in_count  (exp_count),
      .in_exp    (exp_factor),
      .base      (retain),
      .out_valid (pow_valid),
      .out_step  (pow_step),
      .out_exp   (pow_exp)
   );

   // ---- scale the initial rate and saturate ----
   logic [RATE_WIDTH-1:0] r0;
   logic [QW-1:0]         factor;
   logic [PW-1:0]         prod;
   logic [PW:0]           scaled;
   logic [RATE_WIDTH-1:0] rate_in;
   logic [RATE_WIDTH-1:0] rsp_rate_ff;

   assign r0     = (init_rate_ff > RATE_ONE) ? RATE_ONE : init_rate_ff;
   assign factor = (mode_ff == MODE_STEP) ? pow_step : pow_exp;
   assign prod   = r0 * factor;
   assign scaled = ({1'b0, prod} + R_HALF) >> FRAC_BITS;

   always_comb begin
      case (mode_ff)
         MODE_STEP, MODE_EXP: begin
            if (scaled > (PW+1)'(RATE_ONE)) begin
               rate_in = RATE_ONE;
            end else begin
               rate_in = RATE_WIDTH'(scaled);
            end
         end
         MODE_FIXED: rate_in = r0;
         default:    rate_in = r0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pow_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_rate_ff <= rate_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rate  = rsp_rate_ff;

endmodule

/* rtl/core/lrs_div.sv */
module lrs_div
   import lrs_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  logic [TIME_WIDTH-1:0]            in_time,
   input  logic [DIV_WIDTH-1:0]             divisor,
   output logic                             out_valid,
   output logic [TIME_WIDTH+FRAC_BITS-1:0]  out_quot
);

   localparam int STEPS = TIME_WIDTH + FRAC_BITS;

   logic                  valid_ff [1:STEPS];
   logic [STEPS-1:0]      quot_ff  [1:STEPS];
   logic [TIME_WIDTH-1:0] dvd_ff   [1:STEPS-1];
   logic [DIV_WIDTH-1:0]  rem_ff   [1:STEPS-1];

   // one quotient bit per stage: time bits first, then fraction bits
   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic                  cur_valid;
      logic [TIME_WIDTH-1:0] cur_dvd;
      logic [DIV_WIDTH-1:0]  cur_rem;
      logic [STEPS-1:0]      cur_quot;
      logic [DIV_WIDTH:0]    trial;
      logic                  fits;
      logic [DIV_WIDTH-1:0]  rem_in;
      logic [STEPS-1:0]      quot_in;

      if (s == 0) begin : g_head
         assign cur_valid = in_valid;
         assign cur_dvd   = in_time;
         assign cur_rem   = '0;
         assign cur_quot  = '0;
      end else begin : g_body
         assign cur_valid = valid_ff[s];
         assign cur_dvd   = dvd_ff[s];
         assign cur_rem   = rem_ff[s];
         assign cur_quot  = quot_ff[s];
      end

      assign trial  = {cur_rem, cur_dvd[TIME_WIDTH-1]};
      assign fits   = trial >= {1'b0, divisor};
      assign rem_in = fits ? DIV_WIDTH'(trial - {1'b0, divisor}) : trial[DIV_WIDTH-1:0];

      always_comb begin
         quot_in = cur_quot;
         quot_in[STEPS-1-s] = fits;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            quot_ff[s+1] <= quot_in;
         end
      end

      if (s + 1 < STEPS) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[s+1] <= rem_in;
               dvd_ff[s+1] <= cur_dvd << 1;
            end
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_quot  = quot_ff[STEPS];

endmodule

/* rtl/core/lrs_exp.sv */
module lrs_exp
   import lrs_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  logic [TIME_WIDTH+FRAC_BITS-1:0]  in_quot,
   output logic                             out_valid,
   output logic [TIME_WIDTH-1:0]            out_count,
   output logic [FRAC_BITS:0]               out_factor
);

   localparam int QW  = FRAC_BITS + 1;
   localparam int LGW = FRAC_BITS + 1;
   localparam int ZW  = FRAC_BITS + 6;
   localparam int NW  = ZW - FRAC_BITS;
   localparam int SW  = 2 ** NW;
   localparam int CW  = $clog2(EXP_CUTOFF);

   localparam logic [LGW-1:0]      LOG2E    = LGW'(log2e_fix(FRAC_BITS));
   localparam logic [QW-1:0]       Q_ONE    = QW'(1) << FRAC_BITS;
   localparam logic [2*QW-1:0]     Q_HALF   = (2*QW)'(1) << (FRAC_BITS - 1);
   localparam logic [2*FRAC_BITS+1:0] F_HALF = (2*FRAC_BITS+2)'(1) << (FRAC_BITS - 1);

   // ---- head: z = t/T * log2(e) ----
   logic [TIME_WIDTH-1:0]    q;
   logic [FRAC_BITS-1:0]     frac;
   logic                     cut;
   logic [2*FRAC_BITS:0]     frac_prod;
   logic [2*FRAC_BITS+1:0]   frac_sum;
   logic [ZW-1:0]            qz_prod;
   logic [ZW-1:0]            z_in;

   logic                     head_valid_ff;
   logic                     head_cut_ff;
   logic [ZW-1:0]            head_z_ff;
   logic [TIME_WIDTH-1:0]    head_q_ff;

   assign q         = in_quot[TIME_WIDTH+FRAC_BITS-1:FRAC_BITS];
   assign frac      = in_quot[FRAC_BITS-1:0];
   assign cut       = q >= TIME_WIDTH'(EXP_CUTOFF);
   assign frac_prod = frac * LOG2E;
   assign frac_sum  = {1'b0, frac_prod} + F_HALF;
   assign qz_prod   = q[CW-1:0] * LOG2E;
   assign z_in      = qz_prod + ZW'(frac_sum[2*FRAC_BITS+1:FRAC_BITS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
      end else if (advance) begin
         head_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         head_cut_ff <= cut;
         head_z_ff   <= z_in;
         head_q_ff   <= q;
      end
   end

   // ---- one root factor per fraction bit of z ----
   logic                  rt_valid_ff [1:FRAC_BITS];
   logic                  rt_cut_ff   [1:FRAC_BITS];
   logic [ZW-1:0]         rt_z_ff     [1:FRAC_BITS];
   logic [TIME_WIDTH-1:0] rt_q_ff     [1:FRAC_BITS];
   logic [QW-1:0]         rt_acc_ff   [1:FRAC_BITS];

   for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_root
      localparam logic [QW-1:0] ROOT = QW'(exp_root(k, FRAC_BITS));

      logic                  cur_valid;
      logic                  cur_cut;
      logic [ZW-1:0]         cur_z;
      logic [TIME_WIDTH-1:0] cur_q;
      logic [QW-1:0]         cur_acc;
      logic [2*QW-1:0]       prod;
      logic [2*QW-1:0]       prod_rnd;
      logic [QW-1:0]         acc_in;

      if (k == 1) begin : g_head
         assign cur_valid = head_valid_ff;
         assign cur_cut   = head_cut_ff;
         assign cur_z     = head_z_ff;
         assign cur_q     = head_q_ff;
         assign cur_acc   = Q_ONE;
      end else begin : g_body
         assign cur_valid = rt_valid_ff[k-1];
         assign cur_cut   = rt_cut_ff[k-1];
         assign cur_z     = rt_z_ff[k-1];
         assign cur_q     = rt_q_ff[k-1];
         assign cur_acc   = rt_acc_ff[k-1];
      end

      assign prod     = cur_acc * ROOT;
      assign prod_rnd = prod + Q_HALF;
      assign acc_in   = cur_z[FRAC_BITS-k] ? QW'(prod_rnd >> FRAC_BITS) : cur_acc;

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            rt_valid_ff[k] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rt_cut_ff[k] <= cur_cut;
            rt_z_ff[k]   <= cur_z;
            rt_q_ff[k]   <= cur_q;
            rt_acc_ff[k] <= acc_in;
         end
      end
   end

   // ---- tail: zero past the cutoff, else rounded shift by the integer part of z ----
   logic [NW-1:0]          n;
   logic [SW-1:0]          shift_sum;
   logic [QW-1:0]          factor_in;
   logic                   tail_valid_ff;
   logic [TIME_WIDTH-1:0]  tail_q_ff;
   logic [QW-1:0]          tail_factor_ff;

   assign n         = rt_z_ff[FRAC_BITS][ZW-1:FRAC_BITS];
   assign shift_sum = SW'(rt_acc_ff[FRAC_BITS]) + (SW'(1) << (n - NW'(1)));

   always_comb begin
      if (rt_cut_ff[FRAC_BITS]) begin
         factor_in = '0;
      end else if (n == '0) begin
         factor_in = rt_acc_ff[FRAC_BITS];
      end else begin
         factor_in = QW'(shift_sum >> n);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_valid_ff <= 1'b0;
      end else if (advance) begin
         tail_valid_ff <= rt_valid_ff[FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tail_q_ff      <= rt_q_ff[FRAC_BITS];
         tail_factor_ff <= factor_in;
      end
   end

   assign out_valid  = tail_valid_ff;
   assign out_count  = tail_q_ff;
   assign out_factor = tail_factor_ff;

endmodule

/* rtl/core/lrs_pow.sv */
module lrs_pow
   import lrs_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [TIME_WIDTH-1:0]  in_count,
   input  logic [FRAC_BITS:0]     in_exp,
   input  logic [FRAC_BITS:0]     base,
   output logic                   out_valid,
   output logic [FRAC_BITS:0]     out_step,
   output logic [FRAC_BITS:0]     out_exp
);

   localparam int QW = FRAC_BITS + 1;
   localparam logic [QW-1:0]   Q_ONE  = QW'(1) << FRAC_BITS;
   localparam logic [2*QW-1:0] Q_HALF = (2*QW)'(1) << (FRAC_BITS - 1);

   logic                  valid_ff [1:TIME_WIDTH];
   logic [QW-1:0]         acc_ff   [1:TIME_WIDTH];
   logic [QW-1:0]         exp_ff   [1:TIME_WIDTH];
   logic [QW-1:0]         base_ff  [1:TIME_WIDTH-1];
   logic [TIME_WIDTH-1:0] count_ff [1:TIME_WIDTH-1];

   // square and multiply, one epoch-count bit per stage from the low end
   for (genvar s = 0; s < TIME_WIDTH; s++) begin : g_bit
      logic                  cur_valid;
      logic [QW-1:0]         cur_acc;
      logic [QW-1:0]         cur_exp;
      logic [QW-1:0]         cur_base;
      logic [TIME_WIDTH-1:0] cur_count;
      logic [2*QW-1:0]       mul_rnd;
      logic [QW-1:0]         acc_in;

      if (s == 0) begin : g_head
         assign cur_valid = in_valid;
         assign cur_acc   = Q_ONE;
         assign cur_exp   = in_exp;
         assign cur_base  = base;
         assign cur_count = in_count;
      end else begin : g_body
         assign cur_valid = valid_ff[s];
         assign cur_acc   = acc_ff[s];
         assign cur_exp   = exp_ff[s];
         assign cur_base  = base_ff[s];
         assign cur_count = count_ff[s];
      end

      assign mul_rnd = cur_acc * cur_base + Q_HALF;
      assign acc_in  = cur_count[0] ? QW'(mul_rnd >> FRAC_BITS) : cur_acc;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            acc_ff[s+1] <= acc_in;
            exp_ff[s+1] <= cur_exp;
         end
      end

      if (s + 1 < TIME_WIDTH) begin : g_carry
         logic [2*QW-1:0] sq_rnd;

         assign sq_rnd = cur_base * cur_base + Q_HALF;

         always_ff @(posedge clock) begin
            if (advance) begin
               base_ff[s+1]  <= QW'(sq_rnd >> FRAC_BITS);
               count_ff[s+1] <= cur_count >> 1;
            end
         end
      end
   end

   assign out_valid = valid_ff[TIME_WIDTH];
   assign out_step  = acc_ff[TIME_WIDTH];
   assign out_exp   = exp_ff[TIME_WIDTH];

endmodule

/* rtl/core/lrs_retain.sv */
module lrs_retain
   import lrs_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic [DECAY_WIDTH-1:0]  decay,
   output logic [FRAC_BITS:0]      retain
);

   localparam int QW  = FRAC_BITS + 1;
   localparam int XW  = FRAC_BITS + DECAY_WIDTH;
   localparam int PER = RETAIN_STEPS_PER_CYCLE;
   localparam int RS  = (XW + PER - 1) / PER;

   logic [DECAY_WIDTH-1:0] dp;
   logic [DECAY_WIDTH-1:0] keep;
   logic [XW-1:0]          numer;

   // clamp the loss to 100 %, then round((10000 - dp) * 2^F / 10000)
   assign dp    = (decay > DECAY_FULL) ? DECAY_FULL : decay;
   assign keep  = DECAY_FULL - dp;
   assign numer = (XW'(keep) << FRAC_BITS) + XW'(DECAY_ROUND);

   logic [XW-1:0]          x_ff    [1:RS-1];
   logic [DECAY_WIDTH-1:0] rem_ff  [1:RS-1];
   logic [XW-1:0]          quot_ff [1:RS];

   for (genvar s = 0; s < RS; s++) begin : g_stage
      logic [XW-1:0]          cur_x;
      logic [DECAY_WIDTH-1:0] cur_rem;
      logic [XW-1:0]          cur_quot;
      logic [DECAY_WIDTH-1:0] rem_in;
      logic [XW-1:0]          quot_in;

      if (s == 0) begin : g_head
         assign cur_x    = numer;
         assign cur_rem  = '0;
         assign cur_quot = '0;
      end else begin : g_body
         assign cur_x    = x_ff[s];
         assign cur_rem  = rem_ff[s];
         assign cur_quot = quot_ff[s];
      end

      always_comb begin
         logic [DECAY_WIDTH:0] trial;
         int idx;
         rem_in  = cur_rem;
         quot_in = cur_quot;
         for (int j = 0; j < PER; j++) begin
            idx = XW - 1 - (s * PER + j);
            if (idx >= 0) begin
               trial = {rem_in, cur_x[idx]};
               if (trial >= {1'b0, DECAY_FULL}) begin
                  rem_in       = DECAY_WIDTH'(trial - {1'b0, DECAY_FULL});
                  quot_in[idx] = 1'b1;
               end else begin
                  rem_in = trial[DECAY_WIDTH-1:0];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         quot_ff[s+1] <= quot_in;
      end

      if (s + 1 < RS) begin : g_carry
         always_ff @(posedge clock) begin
            x_ff[s+1]   <= cur_x;
            rem_ff[s+1] <= rem_in;
         end
      end
   end

   assign retain = QW'(quot_ff[RS]);

endmodule

/* rtl/core/lrs_checker.sv */
module lrs_checker
   import lrs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [RATE_WIDTH-1:0] rsp_rate
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rate))
      else $error("rsp word changed under stall");

   a_rate_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rate <= RATE_ONE)
      else $error("rate above one");

   // the input side stalls exactly when the output register is full and stalled
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall out of step with output");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind learning_rate_schedule lrs_checker u_lrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_rate  (rsp_rate)
);

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
   import lrs_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam logic [63:0] Q_ONE = 64'd1 << FRAC;
   localparam logic [63:0] Q_HALF = 64'd1 << (FRAC - 1);
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 120;
   localparam int LONG_HOLD = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [TIME_IN_WIDTH-1:0] req_time_step = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [RATE_WIDTH-1:0] rsp_rate;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   // predictor copy of the registers
   logic [MODE_WIDTH-1:0] sched_mode;
   logic [RATE_WIDTH-1:0] sched_rate0;
   logic [DIV_WIDTH-1:0] sched_epoch;
   logic [DECAY_WIDTH-1:0] sched_decay;
   logic [DIV_WIDTH-1:0] sched_tconst;
   logic [63:0] half_roots [1:FRAC];

   logic [RATE_WIDTH-1:0] rate_queue [$];
   int unsigned cycles = 0;
   int unsigned mismatches = 0;
   bit sender_gaps = 1'b0;
   bit receiver_gaps = 1'b0;
   bit hold_request = 1'b0;

   learning_rate_schedule uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_time_step(req_time_step),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_rate(rsp_rate),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [63:0] round_mul(input logic [63:0] a, input logic [63:0] b);
      return (a * b + Q_HALF) >> FRAC;
   endfunction

   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         c = r | (64'd1 << i);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   function automatic logic [63:0] step_gain(input logic [63:0] t);
      logic [63:0] epoch;
      logic [63:0] pct;
      logic [63:0] base;
      logic [63:0] n;
      logic [63:0] acc;
      epoch = (sched_epoch == 0) ? 64'd1 : 64'(sched_epoch);
      pct = (sched_decay > DECAY_FULL) ? 64'(DECAY_FULL) : 64'(sched_decay);
      base = (((64'(DECAY_FULL) - pct) << FRAC) + 64'(DECAY_ROUND)) / 64'(DECAY_FULL);
      n = t / epoch;
      acc = Q_ONE;
      while (n != 0 && acc != 0) begin
         if (n[0]) acc = round_mul(acc, base);
         base = round_mul(base, base);
         n = n >> 1;
      end
      return acc;
   endfunction

   function automatic logic [63:0] exp_gain(input logic [63:0] t);
      logic [63:0] tc;
      logic [63:0] q;
      logic [63:0] frac;
      logic [63:0] lg;
      logic [63:0] z;
      logic [63:0] shift;
      logic [63:0] acc;
      tc = (sched_tconst == 0) ? 64'd1 : 64'(sched_tconst);
      q = t / tc;
      if (q >= EXP_CUTOFF) return 0;
      frac = ((t % tc) << FRAC) / tc;
      lg = (LOG2E_Q60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
      z = q * lg + ((frac * lg + Q_HALF) >> FRAC);
      shift = z >> FRAC;
      acc = Q_ONE;
      for (int k = 1; k <= FRAC; k++)
         if (z[FRAC-k]) acc = round_mul(acc, half_roots[k]);
      if (shift >= 63) return 0;
      if (shift != 0) acc = (acc + (64'd1 << (shift - 1))) >> shift;
      return acc;
   endfunction

   function automatic logic [RATE_WIDTH-1:0] predict_rate(input logic [31:0] ts);
      logic [63:0] r0;
      logic [63:0] rate;
      r0 = (sched_rate0 > RATE_ONE) ? 64'(RATE_ONE) : 64'(sched_rate0);
      if (sched_mode == MODE_STEP) rate = round_mul(r0, step_gain(64'(ts)));
      else if (sched_mode == MODE_EXP) rate = round_mul(r0, exp_gain(64'(ts)));
      else rate = r0;
      if (rate > 64'(RATE_ONE)) rate = 64'(RATE_ONE);
      return rate[RATE_WIDTH-1:0];
   endfunction

   task automatic report_mismatch(input logic [RATE_WIDTH-1:0] want,
                                  input logic [RATE_WIDTH-1:0] got);
      $display("rate mismatch at cycle %0d: expected %0d got %0d", cycles, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rate_queue.size() == 0) begin
            $display("unexpected rate word at cycle %0d: %0d", cycles, rsp_rate);
            mismatches++;
         end else if (rsp_rate !== rate_queue[0]) begin
            report_mismatch(rate_queue[0], rsp_rate);
            void'(rate_queue.pop_front());
         end else begin
            void'(rate_queue.pop_front());
         end
      end
   end

   // receiver side: random stall bursts, or one long hold on request
   initial begin
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   task automatic send_time(input logic [31:0] ts);
      req_valid <= 1'b1;
      req_time_step <= ts;
      do @(posedge clock); while (req_stall);
      rate_queue.push_back(predict_rate(ts));
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (rate_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE:      sched_mode = value[MODE_WIDTH-1:0];
         CSR_INIT_RATE: sched_rate0 = value[RATE_WIDTH-1:0];
         CSR_EPOCH:     sched_epoch = value;
         CSR_DECAY:     sched_decay = value[DECAY_WIDTH-1:0];
         CSR_TCONST:    sched_tconst = value;
         default: ;
      endcase
   endtask

   function automatic logic [31:0] pick_divisor(input int lo_max);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(1, lo_max);
      endcase
   endfunction

   task automatic shuffle_schedule;
      case ($urandom_range(0, 3))
         0: write_reg(CSR_INIT_RATE, 0);
         1: write_reg(CSR_INIT_RATE, 32'(RATE_ONE));
         2: write_reg(CSR_INIT_RATE, $urandom_range(0, 65536));
         default: write_reg(CSR_INIT_RATE, $urandom);
      endcase
      write_reg(CSR_EPOCH, pick_divisor(60));
      case ($urandom_range(0, 3))
         0: write_reg(CSR_DECAY, 0);
         1: write_reg(CSR_DECAY, 32'(DECAY_FULL));
         2: write_reg(CSR_DECAY, $urandom_range(0, 10000));
         default: write_reg(CSR_DECAY, $urandom);
      endcase
      write_reg(CSR_TCONST, pick_divisor(5000));
      write_reg(CSR_MODE, $urandom_range(0, 3));
   endtask

   function automatic logic [31:0] pick_time;
      logic [63:0] d;
      logic [63:0] t;
      d = (sched_mode == MODE_EXP) ? 64'(sched_tconst) : 64'(sched_epoch);
      if (d == 0) d = 1;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 5000);
         2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         default: begin
            t = d * $urandom_range(0, 24) + (d > 1 ? 64'($urandom) % d : 64'd0);
            return (t > 64'hFFFF_FFFF) ? 32'($urandom) : t[31:0];
         end
      endcase
   endfunction

   task automatic test_defaults;
      send_time(0);
      send_time(32'hFFFF_FFFF);
      drain();
   endtask

   task automatic test_fixed_rate;
      write_reg(CSR_INIT_RATE, 0);
      send_time(12345);
      drain();
      write_reg(CSR_INIT_RATE, 32'(RATE_ONE));
      send_time(7);
      drain();
      write_reg(CSR_INIT_RATE, 32'h0001_FFFF);   // above one: saturate
      write_reg(CSR_MODE, MODE_SPARE);
      send_time(32'hFFFF_FFFF);
      send_time(32'h5555_AAAA);
      drain();
   endtask

   task automatic test_step_decay;
      write_reg(CSR_INIT_RATE, 32'(RATE_ONE));
      write_reg(CSR_MODE, MODE_STEP);
      write_reg(CSR_EPOCH, 0);
      write_reg(CSR_DECAY, 0);
      send_time(32'hFFFF_FFFF);
      drain();
      write_reg(CSR_DECAY, 32'(DECAY_FULL));
      send_time(0);
      send_time(1);
      drain();
      write_reg(CSR_DECAY, 32'h3FFF);   // beyond full loss: clamp
      write_reg(CSR_EPOCH, 32'hFFFF_FFFF);
      send_time(32'hFFFF_FFFE);
      send_time(32'hFFFF_FFFF);
      drain();
      write_reg(CSR_DECAY, 1);
      write_reg(CSR_EPOCH, 1);
      send_time(32'hFFFF_FFFF);
      drain();
   endtask

   task automatic test_exp_decay;
      write_reg(CSR_MODE, MODE_EXP);
      write_reg(CSR_TCONST, 0);
      send_time(0);
      send_time(19);
      send_time(20);
      drain();
      write_reg(CSR_TCONST, 1000);
      send_time(19999);
      send_time(20000);
      send_time(500);
      drain();
      write_reg(CSR_TCONST, 32'hFFFF_FFFF);
      send_time(32'hFFFF_FFFE);
      send_time(32'hFFFF_FFFF);
      drain();
   endtask

   task automatic test_unused_index;
      write_reg(3'd5, $urandom);
      write_reg(3'd6, $urandom);
      write_reg(3'd7, $urandom);
      send_time(777);
      drain();
   endtask

   task automatic test_backpressure;
      write_reg(CSR_MODE, MODE_EXP);
      write_reg(CSR_TCONST, 300);
      write_reg(CSR_INIT_RATE, 32'(RATE_ONE));
      hold_request = 1'b1;
      repeat (200) send_time($urandom_range(0, 7000));
      drain();
   endtask

   task automatic test_random;
      for (int ph = 0; ph < 11; ph++) begin
         sender_gaps = (ph < 10);
         receiver_gaps = (ph < 10);
         shuffle_schedule();
         for (int i = 0; i < 100; i++) begin
            send_time(pick_time());
            // pause the sender until every rate is back
            if (i == 50 && ph == 3) begin
               req_valid <= 1'b0;
               while (rate_queue.size() != 0) @(posedge clock);
            end
         end
         drain();
      end
   endtask

   initial begin
      half_roots[1] = floor_root(64'd1 << (2 * FRAC - 1));
      for (int k = 2; k <= FRAC; k++) half_roots[k] = floor_root(half_roots[k-1] << FRAC);
      sched_mode = RST_MODE;
      sched_rate0 = RST_INIT_RATE;
      sched_epoch = RST_EPOCH;
      sched_decay = RST_DECAY;
      sched_tconst = RST_TCONST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_fixed_rate();
      test_step_decay();
      test_exp_decay();
      test_unused_index();
      test_backpressure();
      test_random();
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
